@@ hdl/hpc_pkg.sv @@
package hpc_pkg;

  localparam logic [1:0] CONTENTS_EMPTY = 2'd0;
  localparam logic [1:0] CONTENTS_SOLID = 2'd1;
  localparam logic [1:0] CONTENTS_SKY   = 2'd2;

  localparam logic [1:0] REG_GRID_SIDE   = 2'd0;
  localparam logic [1:0] REG_INV_SPACING = 2'd1;
  localparam logic [1:0] REG_INV_HSTEP   = 2'd2;

  localparam logic [8:0]  GRID_SIDE_RST   = 9'd256;
  localparam logic [31:0] INV_SPACING_RST = 32'd262144;
  localparam logic [31:0] INV_HSTEP_RST   = 32'd16777216;

  localparam int HEIGHT_TOP = 65535;
  localparam int SKY_BAND   = 64;

  // classification result carried from the front end to the interpolator
  typedef struct packed {
    logic       done;     // answer known without reading the store
    logic [1:0] contents;
  } hpc_early_t;

endpackage

@@ hdl/heightfield_point_contents_unit.sv @@
// Query path: accepting edge to out_valid through 2 front-end stages (scaling,
// range tests), 3 store reads, multiply, accumulate, compare. Load: no result.
// Queries overlap in flight, paced by the single-port height memory (three corner
// reads); loads go every cycle unless held off by a query's hold or corner reads.
// Reset: synchronous rst_n restores config and control only, not data or the store.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module heightfield_point_contents_unit import hpc_pkg::*; #(
  parameter int MAX_GRID_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_load_index,
  input  logic [15:0] in_load_height,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_clip_offset,
  output logic        out_valid,
  output logic [1:0]  out_contents,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SIDE_W  = $clog2(MAX_GRID_SIDE + 1);
  localparam int DEPTH   = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = 2 * SIDE_W;

  logic [8:0]  cfg_side_r;
  logic [31:0] cfg_inv_spacing_r, cfg_inv_hstep_r;
  logic [1:0]  reg_sel;
  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_side_r        <= GRID_SIDE_RST;
      cfg_inv_spacing_r <= INV_SPACING_RST;
      cfg_inv_hstep_r   <= INV_HSTEP_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_GRID_SIDE:   cfg_side_r        <= pwdata[8:0];
        REG_INV_SPACING: cfg_inv_spacing_r <= pwdata;
        REG_INV_HSTEP:   cfg_inv_hstep_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_SIDE:   prdata = {23'd0, cfg_side_r};
      REG_INV_SPACING: prdata = cfg_inv_spacing_r;
      REG_INV_HSTEP:   prdata = cfg_inv_hstep_r;
      default:         prdata = 32'd0;
    endcase
  end

  // effective side, clamped
  logic [SIDE_W-1:0] side;
  always_comb begin
    if (cfg_side_r < 9'd2)
      side = SIDE_W'(2);
    else if (32'(cfg_side_r) > 32'(MAX_GRID_SIDE))
      side = SIDE_W'(MAX_GRID_SIDE);
    else
      side = SIDE_W'(cfg_side_r);
  end

  // issue gate: a query raises busy while its hold count runs; a load also waits while
  // corner reads own the store port
  logic [1:0] hold_r;
  logic [1:0] rd_ph_r;   // 0 idle, 1..3 read corner
  logic       acc, acc_q;
  assign busy  = (hold_r != 2'd0) || (!in_kind && rd_ph_r != 2'd0);
  assign acc   = start && !busy;
  assign acc_q = acc && in_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 2'd0;
    end else if (acc_q) begin
      hold_r <= 2'd2;
    end else if (hold_r != 2'd0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  logic              f_vld;
  hpc_early_t        f_early;
  logic [SIDE_W-1:0] f_sx, f_sy;
  logic [15:0]       f_fx, f_fy;
  logic [48:0]       f_zq;

  hpc_front #(.SIDE_W(SIDE_W)) u_front (
    .clk(clk), .rst_n(rst_n), .go(acc_q),
    .pos_x(in_pos_x), .pos_y(in_pos_y), .pos_z(in_pos_z), .clip_offset(in_clip_offset),
    .side(side), .inv_spacing(cfg_inv_spacing_r), .inv_hstep(cfg_inv_hstep_r),
    .res_vld(f_vld), .early(f_early), .sx(f_sx), .sy(f_sy), .fx(f_fx), .fy(f_fy),
    .zq(f_zq)
  );

  // read sequencer: three corner reads; loads are held off while a read is due
  logic              upper_r, early_done_r;
  logic [1:0]        early_c_r;
  logic [SIDE_W-1:0] sx_r, sy_r;
  logic [15:0]       fx_r, fy_r;
  logic [48:0]       zq_r;
  logic [SIDE_W-1:0] side_r;
  logic              upper;
  assign upper = ({1'b0, f_fx} + {1'b0, f_fy}) > 17'd65536;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ph_r <= 2'd0;
    end else if (f_vld) begin
      rd_ph_r <= 2'd1;
    end else if (rd_ph_r == 2'd3) begin
      rd_ph_r <= 2'd0;
    end else if (rd_ph_r != 2'd0) begin
      rd_ph_r <= rd_ph_r + 2'd1;
    end
    if (f_vld) begin
      upper_r      <= upper;
      early_done_r <= f_early.done;
      early_c_r    <= f_early.contents;
      sx_r <= f_sx; sy_r <= f_sy; fx_r <= f_fx; fy_r <= f_fy; zq_r <= f_zq;
      side_r <= side;
    end
  end

  // corners: A=(sx,sy+1), B=(sx+1,sy), C=(sx,sy) or (sx+1,sy+1)
  logic [SIDE_W-1:0] cx, cy;
  logic [IDX_W-1:0]  rd_idx;
  always_comb begin
    case (rd_ph_r)
      2'd1:    begin cx = sx_r;        cy = sy_r + 1'b1; end
      2'd2:    begin cx = sx_r + 1'b1; cy = sy_r;        end
      2'd3:    begin cx = upper_r ? sx_r + 1'b1 : sx_r;
                     cy = upper_r ? sy_r + 1'b1 : sy_r;  end
      default: begin cx = sx_r;        cy = sy_r;        end
    endcase
  end
  assign rd_idx = IDX_W'(cy) * IDX_W'(side_r) + IDX_W'(cx);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;
  logic        wr_en;
  assign wr_en = acc && !in_kind && (32'(in_load_index) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[ADDR_W'(in_load_index)] <= in_load_height;
    else if (rd_ph_r != 2'd0)
      rd_data_r <= mem[ADDR_W'(rd_idx)];
  end

  // corner weight is picked with the read, while the query's fractions are current
  logic [16:0] wt, wt_r;
  always_comb begin
    case (rd_ph_r)
      2'd1:    wt = upper_r ? 17'd65536 - 17'(fx_r) : 17'(fy_r);
      2'd2:    wt = upper_r ? 17'd65536 - 17'(fy_r) : 17'(fx_r);
      2'd3:    wt = upper_r ? 17'(fx_r) + 17'(fy_r) - 17'd65536
                            : 17'd65536 - 17'(fx_r) - 17'(fy_r);
      default: wt = 17'd0;
    endcase
  end

  // multiply each corner by its weight, accumulate
  logic [1:0]  dp_r;  // which corner rd_data_r holds, 0 none
  logic [32:0] prod_r;
  logic        pv_r, pfirst_r, plast_r;
  logic [48:0] acc_r;
  logic        fin_r, fin_early_r;
  logic [1:0]  fin_c_r;
  logic [48:0] fin_zq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r <= 2'd0; pv_r <= 1'b0; pfirst_r <= 1'b0; plast_r <= 1'b0; fin_r <= 1'b0;
    end else begin
      dp_r     <= rd_ph_r;
      pv_r     <= (dp_r != 2'd0);
      pfirst_r <= (dp_r == 2'd1);
      plast_r  <= (dp_r == 2'd3);
      fin_r    <= pv_r && plast_r;
    end
    wt_r   <= wt;
    prod_r <= rd_data_r * wt_r;
    // the first product restarts the sum, so queries can follow back to back
    if (pv_r)
      acc_r <= (pfirst_r ? 49'd0 : acc_r) + 49'(prod_r);
    // the next query's context lands right after the last read; keep this one
    if (rd_ph_r == 2'd3) begin
      fin_early_r <= early_done_r;
      fin_c_r     <= early_c_r;
      fin_zq_r    <= zq_r;
    end
  end

  logic [48:0] total;
  assign total = acc_r;

  logic [1:0] res_c;
  assign res_c = fin_early_r ? fin_c_r
               : ((fin_zq_r <= total) ? CONTENTS_SOLID : CONTENTS_EMPTY);

  // acc_r holds the final sum the cycle after the last product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fin_r;
    end
    out_contents <= res_c;
  end

  assert property (@(posedge clk) disable iff (!rst_n) acc_q |=> busy);
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> rd_ph_r == 2'd0) else $error("load collides with read");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_contents != 2'd3) else $error("bad contents code");

endmodule

@@ hdl/hpc_front.sv @@
// Scales the point to grid units and does the range tests (two stages).
module hpc_front import hpc_pkg::*; #(
  parameter int SIDE_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [31:0]        pos_x,
  input  logic [31:0]        pos_y,
  input  logic [31:0]        pos_z,
  input  logic [31:0]        clip_offset,
  input  logic [SIDE_W-1:0]  side,
  input  logic [31:0]        inv_spacing,
  input  logic [31:0]        inv_hstep,
  output logic               res_vld,
  output hpc_early_t         early,
  output logic [SIDE_W-1:0]  sx,
  output logic [SIDE_W-1:0]  sy,
  output logic [15:0]        fx,
  output logic [15:0]        fy,
  output logic [48:0]        zq
);

  logic               s1_vld_r;
  logic signed [64:0] xp_r, yp_r;
  logic        [64:0] zm_r;
  logic               zneg_r, clip_r;
  logic [SIDE_W-1:0]  side_r;

  logic signed [32:0] zs;
  logic        [32:0] zabs;
  assign zs   = $signed({pos_z[31], pos_z}) + $signed({clip_offset[31], clip_offset});
  assign zabs = zs[32] ? 33'(-zs) : zs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= go;
    end
    if (go) begin
      xp_r   <= 65'($signed(pos_x)) * 65'($signed({1'b0, inv_spacing}));
      yp_r   <= 65'($signed(pos_y)) * 65'($signed({1'b0, inv_spacing}));
      zm_r   <= 65'(zabs) * 65'(inv_hstep);
      zneg_r <= zs[32];
      clip_r <= (clip_offset != 32'd0);
      side_r <= side;
    end
  end

  logic signed [48:0] xq, yq;
  logic        [48:0] zqv;
  logic signed [48:0] lim1, lim0;
  hpc_early_t         ec;
  assign xq   = 49'(xp_r >>> 16);
  assign yq   = 49'(yp_r >>> 16);
  assign zqv  = 49'(zm_r >> 16);
  assign lim1 = $signed({16'd0, 33'(side_r - 1'b1) << 16});
  assign lim0 = $signed({16'd0, 33'(side_r) << 16});

  function automatic logic [1:0] edge_code(input logic hard, input logic clip);
    return (hard || clip) ? CONTENTS_SOLID : CONTENTS_SKY;
  endfunction

  always_comb begin
    ec.done     = 1'b1;
    ec.contents = CONTENTS_SOLID;
    if (zneg_r && zm_r != 65'd0) begin
      ec.contents = CONTENTS_SOLID;
    end else if (zqv > 49'(HEIGHT_TOP) << 16) begin
      ec.contents = edge_code(zqv > 49'(HEIGHT_TOP + SKY_BAND) << 16, clip_r);
    end else if (xq < 0) begin
      ec.contents = edge_code(xq <= -49'sd65536, clip_r);
    end else if (yq < 0) begin
      ec.contents = edge_code(yq <= -49'sd65536, clip_r);
    end else if (xq >= lim1) begin
      ec.contents = edge_code(xq >= lim0, clip_r);
    end else if (yq >= lim1) begin
      ec.contents = edge_code(yq >= lim0, clip_r);
    end else begin
      ec.done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= s1_vld_r;
    end
    early <= ec;
    sx    <= SIDE_W'(xq[48:16]);
    sy    <= SIDE_W'(yq[48:16]);
    fx    <= xq[15:0];
    fy    <= yq[15:0];
    zq    <= zqv;
  end

endmodule
